@@ rtl/html_tag_strip_entity_decode_top_macros.svh @@
// Assertion macros for the tag stripper with entity decoding.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef HTML_TAG_STRIP_ENTITY_DECODE_TOP_MACROS_SVH
`define HTML_TAG_STRIP_ENTITY_DECODE_TOP_MACROS_SVH

// Property checked at every clock edge outside reset.
`define HTSED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HTSED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/htsed_pkg.sv @@
// Shared types, character codes and entity tables of the tag stripper.
// No dependencies; every other file but the assertion macros header imports this package.
package htsed_pkg;

  localparam int BYTE_W      = 8;
  localparam int PEND_DEPTH  = 6;
  localparam int QUEUE_DEPTH = PEND_DEPTH + 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_COUNT   = 5;

  localparam logic [BYTE_W-1:0] CHAR_LT  = 8'h3C;
  localparam logic [BYTE_W-1:0] CHAR_GT  = 8'h3E;
  localparam logic [BYTE_W-1:0] CHAR_AMP = 8'h26;
  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

  // Entity spellings, '&' included, padded with zero bytes.
  localparam logic [BYTE_W-1:0] ENT_TEXT [ENT_COUNT][PEND_DEPTH] = '{
    '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
    '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
    '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B}
  };
  localparam logic [CNT_W-1:0] ENT_LEN [ENT_COUNT] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6};
  localparam logic [BYTE_W-1:0] ENT_VALUE [ENT_COUNT] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h20};

  typedef logic [PEND_DEPTH-1:0][BYTE_W-1:0]  held_t;
  typedef logic [QUEUE_DEPTH-1:0][BYTE_W-1:0] queue_t;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } ctrl_state_e;

  typedef struct packed {
    logic step_input;
    logic step_replay;
    logic give_up;
    logic emit_end;
  } cmd_t;

  typedef struct packed {
    logic replay;
    logic holding;
    logic out_free;
  } status_t;

endpackage

@@ rtl/htsed_if.sv @@
// Stream channel interfaces: markup bytes in, plain-text bytes out.
// Depends on htsed_pkg for the byte width.
interface htsed_in_if import htsed_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              last;

  modport source (output valid, in_byte, last, input ready);
  modport sink   (input valid, in_byte, last, output ready);
endinterface

interface htsed_out_if import htsed_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              end_of_text;

  modport source (output valid, out_byte, end_of_text, input ready);
  modport sink   (input valid, out_byte, end_of_text, output ready);
endinterface

@@ rtl/htsed_match.sv @@
// Entity matcher: compares the held candidate plus the current byte
// against the entity table. Depends on htsed_pkg.
module htsed_match import htsed_pkg::*; (
  input  held_t             held_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [BYTE_W-1:0] cur_i,
  output logic              full_o,
  output logic              prefix_o,
  output logic [BYTE_W-1:0] value_o
);

  logic ok;

  always_comb begin
    full_o   = 1'b0;
    prefix_o = 1'b0;
    value_o  = '0;
    ok       = 1'b0;
    for (int e = 0; e < ENT_COUNT; e++) begin
      ok = 1'b1;
      for (int i = 0; i < PEND_DEPTH; i++) begin
        if (CNT_W'(i) < count_i) begin
          ok = ok && (held_i[i] == ENT_TEXT[e][i]);
        end else if (CNT_W'(i) == count_i) begin
          ok = ok && (cur_i == ENT_TEXT[e][i]);
        end
      end
      // The first complete match wins; later prefixes no longer matter.
      if (ok && !full_o) begin
        if ((count_i + CNT_W'(1)) == ENT_LEN[e]) begin
          full_o  = 1'b1;
          value_o = ENT_VALUE[e];
        end else if (count_i < ENT_LEN[e]) begin
          prefix_o = 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/htsed_datapath.sv @@
// Datapath: byte queue (held candidate followed by bytes to replay), tag flag,
// entity matcher and output register. Depends on htsed_pkg and htsed_match.
module htsed_datapath import htsed_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              end_of_text_o
);

  // Entries below pc_q are the candidate; entries from pc_q up to but not including tc_q are replayed.
  queue_t            q_q, q_d, q_ext;
  logic [CNT_W-1:0]  pc_q, pc_d, tc_q, tc_d, shift;
  logic [CNT_W:0]    src_idx;
  logic              tag_q, tag_d;
  logic              ov_q, ov_d, oe_q, oe_d;
  logic [BYTE_W-1:0] ob_q, ob_d;
  logic [BYTE_W-1:0] cur, emit_byte;
  logic              emit, emit_end;
  logic              m_full, m_prefix;
  logic [BYTE_W-1:0] m_value;

  assign status_o.replay   = (tc_q != pc_q);
  assign status_o.holding  = (pc_q != '0);
  assign status_o.out_free = !ov_q || out_ready_i;

  assign cur = cmd_i.step_input ? in_byte_i : q_q[pc_q];

  htsed_match u_match (
    .held_i   (q_q[PEND_DEPTH-1:0]),
    .count_i  (pc_q),
    .cur_i    (cur),
    .full_o   (m_full),
    .prefix_o (m_prefix),
    .value_o  (m_value)
  );

  always_comb begin
    q_ext = q_q;
    if (cmd_i.step_input) begin
      q_ext[pc_q] = in_byte_i;
    end
    pc_d      = pc_q;
    tag_d     = tag_q;
    shift     = '0;
    emit      = 1'b0;
    emit_byte = cur;
    emit_end  = 1'b0;
    if (cmd_i.step_input || cmd_i.step_replay) begin
      if (pc_q == '0) begin
        if (cur == CHAR_LT) begin
          tag_d = 1'b1;
          shift = CNT_W'(1);
        end else if (cur == CHAR_GT) begin
          tag_d = 1'b0;
          shift = CNT_W'(1);
        end else if (tag_q) begin
          shift = CNT_W'(1);
        end else if (cur == CHAR_AMP) begin
          pc_d = CNT_W'(1);
        end else begin
          emit  = 1'b1;
          shift = CNT_W'(1);
        end
      end else if (pc_q == CNT_W'(PEND_DEPTH)) begin
        // Candidate is full: give up and leave the current byte for replay.
        emit      = 1'b1;
        emit_byte = CHAR_AMP;
        shift     = CNT_W'(1);
        pc_d      = '0;
      end else if (m_full) begin
        emit      = 1'b1;
        emit_byte = m_value;
        shift     = pc_q + CNT_W'(1);
        pc_d      = '0;
      end else if (m_prefix) begin
        pc_d = pc_q + CNT_W'(1);
      end else begin
        emit      = 1'b1;
        emit_byte = CHAR_AMP;
        shift     = CNT_W'(1);
        pc_d      = '0;
      end
    end else if (cmd_i.give_up) begin
      emit      = 1'b1;
      emit_byte = CHAR_AMP;
      shift     = CNT_W'(1);
      pc_d      = '0;
    end else if (cmd_i.emit_end) begin
      emit      = 1'b1;
      emit_byte = CHAR_NUL;
      emit_end  = 1'b1;
      tag_d     = 1'b0;
    end
    tc_d = tc_q + CNT_W'(cmd_i.step_input) - shift;

    src_idx = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      src_idx = (CNT_W + 1)'(i) + {1'b0, shift};
      if (src_idx < (CNT_W + 1)'(QUEUE_DEPTH)) begin
        q_d[i] = q_ext[src_idx[CNT_W-1:0]];
      end else begin
        q_d[i] = q_ext[i];
      end
    end

    ov_d = ov_q;
    ob_d = ob_q;
    oe_d = oe_q;
    if (out_ready_i) begin
      ov_d = 1'b0;
    end
    if (emit) begin
      ov_d = 1'b1;
      ob_d = emit_byte;
      oe_d = emit_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      tc_q  <= '0;
      tag_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      pc_q  <= pc_d;
      tc_q  <= tc_d;
      tag_q <= tag_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q  <= q_d;
    ob_q <= ob_d;
    oe_q <= oe_d;
  end

  assign out_valid_o   = ov_q;
  assign out_byte_o    = ob_q;
  assign end_of_text_o = oe_q;

endmodule

@@ rtl/htsed_ctrl.sv @@
// Controller: decides each cycle whether to take an input beat, replay a
// held byte, give up a candidate or close the text. Depends on htsed_pkg.
module htsed_ctrl import htsed_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (in_valid_i && in_ready_o && in_last_i) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (cmd_o.emit_end) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        in_ready_o        = status_i.out_free && !status_i.replay;
        cmd_o.step_input  = in_valid_i && in_ready_o;
        cmd_o.step_replay = status_i.out_free && status_i.replay;
      end
      ST_FLUSH: begin
        if (status_i.out_free) begin
          if (status_i.replay) begin
            cmd_o.step_replay = 1'b1;
          end else if (status_i.holding) begin
            cmd_o.give_up = 1'b1;
          end else begin
            cmd_o.emit_end = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/html_tag_strip_entity_decode_top.sv @@
// Markup tag stripper with entity decoding.
// in_i carries one markup byte per beat, with last on the final byte of a text.
// out_o carries plain-text bytes; a zero byte with end_of_text closes each text.
// Bytes between '<' and '>' are dropped; &amp; &lt; &gt; &quot; &nbsp; become
// one byte each. A '&' and what follows it are held until the entity is decided.
// A plain byte or the byte that completes an entity reaches the output register
// as its beat is taken. Throughput: one input beat per cycle while the output
// register is free and no held byte waits for replay. When a held candidate
// fails, the block emits '&' and then replays the held bytes one at a time,
// during which input is not accepted. After the last beat, it replays held bytes,
// gives up each candidate left by emitting its '&', then emits the terminator.
// The rate is set by the single-entry output register and the one-byte-a-cycle
// step through the held-byte queue.
// When the receiver stalls with a result waiting, no step is taken and input
// ready stays low until that result is taken in the same or a later cycle.
// Reset leaves the block outside a tag with nothing held and no result waiting.
// Depends on htsed_pkg, htsed_if, htsed_match, htsed_datapath and htsed_ctrl.
`include "html_tag_strip_entity_decode_top_macros.svh"

module html_tag_strip_entity_decode_top import htsed_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  htsed_in_if.sink    in_i,
  htsed_out_if.source out_o
);

  cmd_t    cmd;
  status_t status;

  htsed_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  htsed_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_byte_i     (in_i.in_byte),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_byte_o    (out_o.out_byte),
    .end_of_text_o (out_o.end_of_text)
  );

  `HTSED_ASSERT_NEXT(a_last_starts_flush, in_i.valid && in_i.ready && in_i.last, !in_i.ready, "input taken right after the last beat")
  `HTSED_ASSERT(a_ready_only_without_replay, in_i.ready |-> !status.replay, "input ready while held bytes wait for replay")
  `HTSED_ASSERT(a_end_only_when_empty, cmd.emit_end |-> !status.holding && !status.replay, "terminator issued with bytes still held")

endmodule

@@ dv/tb_top.sv @@
// Testbench for the markup tag stripper with entity decoding: directed texts first, then
// random texts built from entities, cut-short entities, tags and plain runs.
// Depends on htsed_pkg, the htsed_if channel interfaces and html_tag_strip_entity_decode_top.
module tb_top;
  import htsed_pkg::*;

  localparam logic [BYTE_W-1:0] CHAR_QUOT  = 8'h22;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam int unsigned ITEM_TARGET = 350;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_text;
  } plain_char_t;

  string             entity_spelling [ENT_COUNT] = '{"&amp;", "&lt;", "&gt;", "&quot;", "&nbsp;"};
  logic [BYTE_W-1:0] entity_char [ENT_COUNT] = '{CHAR_AMP, CHAR_LT, CHAR_GT, CHAR_QUOT,
                                                 CHAR_SPACE};

  class plain_text_sb;
    bit                in_tag;
    logic [BYTE_W-1:0] held [PEND_DEPTH];
    int unsigned       held_n;
    plain_char_t       plain_q [$];
    int unsigned       mismatch_cnt;

    function void emit_char(logic [BYTE_W-1:0] b, logic eot);
      plain_char_t c;
      c.out_byte    = b;
      c.end_of_text = eot;
      plain_q.push_back(c);
    endfunction

    // A failed candidate gives back its '&' and then replays the bytes held after it.
    function void drop_candidate();
      logic [BYTE_W-1:0] saved [PEND_DEPTH];
      int unsigned       n;
      saved  = held;
      n      = (held_n > PEND_DEPTH) ? PEND_DEPTH : held_n;
      held_n = 0;
      emit_char(CHAR_AMP, 1'b0);
      for (int k = 1; k < n; k++) take_byte(saved[k]);
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      bit prefix;
      bit same;
      prefix = 1'b0;
      if (held_n == 0) begin
        if (b == CHAR_LT) begin
          in_tag = 1'b1;
        end else if (b == CHAR_GT) begin
          in_tag = 1'b0;
        end else if (!in_tag) begin
          if (b == CHAR_AMP) begin
            held[0] = b;
            held_n  = 1;
          end else begin
            emit_char(b, 1'b0);
          end
        end
        return;
      end
      if (held_n >= PEND_DEPTH) begin
        drop_candidate();
        take_byte(b);
        return;
      end
      held[held_n] = b;
      held_n++;
      for (int e = 0; e < ENT_COUNT; e++) begin
        if (held_n <= entity_spelling[e].len()) begin
          same = 1'b1;
          for (int i = 0; i < held_n; i++) begin
            if (held[i] != entity_spelling[e][i]) same = 1'b0;
          end
          if (same) begin
            if (held_n == entity_spelling[e].len()) begin
              held_n = 0;
              emit_char(entity_char[e], 1'b0);
              return;
            end
            prefix = 1'b1;
          end
        end
      end
      if (!prefix) drop_candidate();
    endfunction

    function void note_markup_byte(logic [BYTE_W-1:0] b, logic fin);
      take_byte(b);
      if (fin) begin
        while (held_n > 0) drop_candidate();
        emit_char(CHAR_NUL, 1'b1);
        in_tag = 1'b0;
        held_n = 0;
      end
    endfunction

    function void check_plain_byte(logic [BYTE_W-1:0] b, logic eot);
      plain_char_t want;
      if (plain_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("%0t: unexpected result out_byte=%02h end_of_text=%0b", $time, b, eot);
        return;
      end
      want = plain_q.pop_front();
      if (b !== want.out_byte || eot !== want.end_of_text) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("%0t: mismatch: expected out_byte=%02h end_of_text=%0b, got %02h %0b",
                   $time, want.out_byte, want.end_of_text, b, eot);
      end
    endfunction
  endclass

  logic         clk_i  = 1'b0;
  logic         rst_ni = 1'b0;
  int unsigned  src_idle_pct;
  int unsigned  sink_idle_pct;
  int unsigned  sent_cnt;
  plain_text_sb sb = new();

  htsed_in_if  in_if ();
  htsed_out_if out_if ();

  html_tag_strip_entity_decode_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #10 clk_i = ~clk_i;

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.last    <= fin;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_markup_byte(b, fin);
    sent_cnt++;
  endtask

  task automatic send_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
  endtask

  task automatic send_random_text();
    logic [BYTE_W-1:0] text [$];
    int                tokens;
    int                r;
    int                e;
    int                n;
    tokens = $urandom_range(12, 1);
    repeat (tokens) begin
      r = $urandom_range(99);
      e = $urandom_range(ENT_COUNT - 1);
      if (r < 40) begin
        for (int i = 0; i < entity_spelling[e].len(); i++) text.push_back(entity_spelling[e][i]);
      end else if (r < 60) begin
        // A cut-short entity, sometimes followed by a stray byte and sometimes left open.
        n = $urandom_range(entity_spelling[e].len() - 1, 1);
        for (int i = 0; i < n; i++) text.push_back(entity_spelling[e][i]);
        if ($urandom_range(1)) text.push_back(BYTE_W'($urandom_range(255, 1)));
      end else if (r < 75) begin
        text.push_back(CHAR_LT);
        repeat ($urandom_range(4)) text.push_back(BYTE_W'($urandom_range(255, 1)));
        text.push_back(CHAR_GT);
      end else begin
        repeat ($urandom_range(4, 1)) text.push_back(BYTE_W'($urandom_range(255, 1)));
      end
    end
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) sb.check_plain_byte(out_if.out_byte, out_if.end_of_text);
      out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    in_if.valid   <= 1'b0;
    in_if.in_byte <= '0;
    in_if.last    <= 1'b0;
    src_idle_pct  = 23;
    sink_idle_pct = 70;
    sent_cnt      = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("&lt;", 1'b0);
    send_text("&quot;", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(CHAR_NUL, 1'b0);
    // A bracket inside a candidate ends it, then opens and closes a tag.
    send_text("&g<x>", 1'b0);
    // The second '&' fails the first candidate and starts one that the flush gives back.
    send_text("&&", 1'b1);
    send_text("&amp", 1'b1);

    while (sent_cnt < ITEM_TARGET / 3) send_random_text();
    src_idle_pct  = 70;
    sink_idle_pct = 23;
    while (sent_cnt < 2 * ITEM_TARGET / 3) send_random_text();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    while (sent_cnt < ITEM_TARGET) send_random_text();
    in_if.valid <= 1'b0;

    while (sb.plain_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatch_cnt == 0 && sb.plain_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
